>>> rtl/core/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg: shared definitions for the clamped PID controller
// Number format, register indexes, stage load controls and the clamp helper.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Signed data format: Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS
  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  // Gains are unsigned Q16.16
  localparam int GAIN_WIDTH  = 32;
  // Error and measurement difference carry one extra bit
  localparam int ERR_WIDTH   = DATA_WIDTH + 1;
  localparam int PROD_WIDTH  = ERR_WIDTH + GAIN_WIDTH;
  localparam int CFG_WIDTH   = (GAIN_WIDTH > DATA_WIDTH) ? GAIN_WIDTH : DATA_WIDTH;
  localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int ADDR_WIDTH  = 3;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // Register indexes
  localparam logic [ADDR_WIDTH-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [ADDR_WIDTH-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [ADDR_WIDTH-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [ADDR_WIDTH-1:0] REG_TARGET_VALUE  = 3'd3;
  localparam logic [ADDR_WIDTH-1:0] REG_DRIVE_FLOOR   = 3'd4;
  localparam logic [ADDR_WIDTH-1:0] REG_DRIVE_CEILING = 3'd5;

  // Load strobes for the three stages of a gain multiplier
  typedef struct packed {
    logic ld_mag;
    logic ld_prod;
    logic ld_term;
  } mul_ld_t;

  // Clamp a widened sum to [lo, hi]
  function automatic logic signed [DATA_WIDTH-1:0] clamp_data(
    input logic signed [DATA_WIDTH+1:0] v,
    input logic signed [DATA_WIDTH-1:0] lo,
    input logic signed [DATA_WIDTH-1:0] hi
  );
    logic signed [DATA_WIDTH-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped: PID controller with clamped integral
// Derivative on measurement, anti-windup clamp, saturating Q16.16 arithmetic.
// ----------------------------------------------------------------------------
// Each measured sample accepted on the s_ stream yields one drive value on
// the m_ stream. The datapath is a seven-stage pipeline (input capture,
// error, magnitude, multiply, round/saturate, integral update, output clamp)
// with elastic per-stage handshaking, so one sample is taken every cycle
// while the m_ stream accepts drive values. The integral is updated in a
// single stage, which is what allows the one-sample per cycle rate. Writing
// any gain or the setpoint clears the integral; a limit write that would
// leave floor not below ceiling is ignored. Write configuration only while
// no samples are in flight.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [pidc_pkg::ADDR_WIDTH-1:0]     cfg_addr,
  input  logic [pidc_pkg::CFG_WIDTH-1:0]      cfg_wdata,
  // Sample stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pidc_pkg::TDATA_WIDTH-1:0]    s_tdata,   // [DATA_WIDTH-1:0] measured
  // Drive stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pidc_pkg::TDATA_WIDTH-1:0]    m_tdata    // [DATA_WIDTH-1:0] drive
);
  import pidc_pkg::*;

  localparam int NS = 7;

  // Configuration registers
  logic        [GAIN_WIDTH-1:0] prop_gain;
  logic        [GAIN_WIDTH-1:0] integ_gain;
  logic        [GAIN_WIDTH-1:0] deriv_gain;
  logic signed [DATA_WIDTH-1:0] target_value;
  logic signed [DATA_WIDTH-1:0] drive_floor;
  logic signed [DATA_WIDTH-1:0] drive_ceiling;
  logic signed [DATA_WIDTH-1:0] cfg_sval;
  logic                         clr_integ;

  // Controller state
  logic signed [DATA_WIDTH-1:0] integral_acc;
  logic signed [DATA_WIDTH-1:0] last_measured;
  logic                         first_pending;

  // Pipeline control
  logic [NS-1:0] vld;
  logic [NS-1:0] vld_next;
  logic [NS:0]   rdy;
  logic [NS-1:0] ld;
  mul_ld_t       mul_ld;

  // Pipeline payload
  logic signed [DATA_WIDTH-1:0] smp0;
  logic signed [DATA_WIDTH-1:0] prv0;
  logic                         frst0;
  logic signed [ERR_WIDTH-1:0]  err1;
  logic signed [ERR_WIDTH-1:0]  dif1;
  logic                         frst1;
  logic                         frst2;
  logic                         frst3;
  logic                         frst4;
  logic signed [DATA_WIDTH-1:0] term_p;
  logic signed [DATA_WIDTH-1:0] term_i;
  logic signed [DATA_WIDTH-1:0] term_d;
  logic signed [DATA_WIDTH:0]   pd5;
  logic signed [DATA_WIDTH-1:0] drive;

  logic signed [DATA_WIDTH-1:0] meas_in;
  logic signed [DATA_WIDTH+1:0] integ_sum;
  logic signed [DATA_WIDTH+1:0] out_sum;

  assign meas_in  = signed'(s_tdata[DATA_WIDTH-1:0]);
  assign cfg_sval = signed'(cfg_wdata[DATA_WIDTH-1:0]);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= '0;
      integ_gain    <= '0;
      deriv_gain    <= '0;
      target_value  <= '0;
      drive_floor   <= '0;
      drive_ceiling <= DATA_MAX;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PROP_GAIN:    prop_gain    <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_INTEG_GAIN:   integ_gain   <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_DERIV_GAIN:   deriv_gain   <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_TARGET_VALUE: target_value <= cfg_sval;
        REG_DRIVE_FLOOR: begin
          if (cfg_sval < drive_ceiling) drive_floor <= cfg_sval;
        end
        REG_DRIVE_CEILING: begin
          if (drive_floor < cfg_sval) drive_ceiling <= cfg_sval;
        end
        default: ;
      endcase
    end
  end

  assign clr_integ = cfg_we && (cfg_addr == REG_PROP_GAIN || cfg_addr == REG_INTEG_GAIN ||
                                cfg_addr == REG_DERIV_GAIN || cfg_addr == REG_TARGET_VALUE);

  // Stage ready chain and load strobes
  always_comb begin
    rdy[NS] = m_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    ld[0]       = s_tvalid && rdy[0];
    vld_next[0] = rdy[0] ? s_tvalid : vld[0];
    for (int i = 1; i < NS; i++) begin
      ld[i]       = vld[i-1] && rdy[i];
      vld_next[i] = rdy[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NS-1];

  // Capture sample, remember it for the next derivative
  always_ff @(posedge clk) begin
    if (rst) begin
      last_measured <= '0;
      first_pending <= 1'b1;
    end else if (ld[0]) begin
      last_measured <= meas_in;
      first_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      smp0  <= meas_in;
      prv0  <= last_measured;
      frst0 <= first_pending;
    end
  end

  // Form error and measurement difference exactly
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      err1  <= ERR_WIDTH'(target_value) - ERR_WIDTH'(smp0);
      dif1  <= ERR_WIDTH'(prv0) - ERR_WIDTH'(smp0);
      frst1 <= frst0;
    end
  end

  // Carry first-sample flag alongside the multipliers
  always_ff @(posedge clk) begin
    if (ld[2]) frst2 <= frst1;
    if (ld[3]) frst3 <= frst2;
    if (ld[4]) frst4 <= frst3;
  end

  assign mul_ld = '{ld_mag: ld[2], ld_prod: ld[3], ld_term: ld[4]};

  pidc_gain_mul u_mul_p (
    .clk  (clk),
    .ld   (mul_ld),
    .a    (err1),
    .g    (prop_gain),
    .term (term_p)
  );

  pidc_gain_mul u_mul_i (
    .clk  (clk),
    .ld   (mul_ld),
    .a    (err1),
    .g    (integ_gain),
    .term (term_i)
  );

  pidc_gain_mul u_mul_d (
    .clk  (clk),
    .ld   (mul_ld),
    .a    (dif1),
    .g    (deriv_gain),
    .term (term_d)
  );

  // Advance the integral, sum proportional and derivative terms
  assign integ_sum = (DATA_WIDTH+2)'(integral_acc) + (DATA_WIDTH+2)'(term_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
    end else if (clr_integ) begin
      integral_acc <= '0;
    end else if (ld[5]) begin
      integral_acc <= clamp_data(integ_sum, drive_floor, drive_ceiling);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      pd5 <= (DATA_WIDTH+1)'(term_p) + (frst4 ? '0 : (DATA_WIDTH+1)'(term_d));
    end
  end

  // Add integral and clamp into the output register
  assign out_sum = (DATA_WIDTH+2)'(pd5) + (DATA_WIDTH+2)'(integral_acc);

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      drive <= clamp_data(out_sum, drive_floor, drive_ceiling);
    end
  end

  assign m_tdata = TDATA_WIDTH'(unsigned'(drive));

`ifndef SYNTHESIS
  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_drive_in_limits : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (drive >= drive_floor && drive <= drive_ceiling))
    else $error("drive outside limits");

  a_limits_ordered : assert property (@(posedge clk) disable iff (rst)
    drive_floor < drive_ceiling)
    else $error("floor not below ceiling");

  a_gain_clears_integral : assert property (@(posedge clk) disable iff (rst)
    clr_integ |=> integral_acc == '0)
    else $error("integral not cleared by gain or setpoint write");

  a_first_clears : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !first_pending)
    else $error("first-sample flag still set after a transaction");
`endif

endmodule

>>> rtl/core/pidc_gain_mul.sv
// ----------------------------------------------------------------------------
// pidc_gain_mul: three-stage signed-by-gain multiplier
// Takes magnitude, multiplies by an unsigned gain, then rounds half away from
// zero, drops the fraction bits and saturates to the signed data range.
// ----------------------------------------------------------------------------
module pidc_gain_mul (
  input  logic                                     clk,
  input  pidc_pkg::mul_ld_t                        ld,
  input  logic signed [pidc_pkg::ERR_WIDTH-1:0]    a,
  input  logic        [pidc_pkg::GAIN_WIDTH-1:0]   g,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0]   term
);
  import pidc_pkg::*;

  localparam int QW = PROD_WIDTH + 1 - FRAC_BITS;
  localparam logic [PROD_WIDTH:0] RND = (PROD_WIDTH + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [QW-1:0] LIM_POS = QW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (DATA_WIDTH - 1);

  logic [ERR_WIDTH-1:0]  mag;
  logic                  mag_neg;
  logic [PROD_WIDTH-1:0] prod;
  logic                  prod_neg;

  logic [ERR_WIDTH-1:0]  a_u;
  logic [PROD_WIDTH:0]   rsum;
  logic [QW-1:0]         q;
  logic [QW-1:0]         lim;
  logic [DATA_WIDTH-1:0] qs;

  assign a_u = unsigned'(a);

  // Split into sign and magnitude
  always_ff @(posedge clk) begin
    if (ld.ld_mag) begin
      mag     <= a[ERR_WIDTH-1] ? (~a_u + ERR_WIDTH'(1)) : a_u;
      mag_neg <= a[ERR_WIDTH-1];
    end
  end

  // Multiply magnitude by gain
  always_ff @(posedge clk) begin
    if (ld.ld_prod) begin
      prod     <= PROD_WIDTH'(mag) * PROD_WIDTH'(g);
      prod_neg <= mag_neg;
    end
  end

  // Round, shift out fraction, saturate, restore sign
  always_comb begin
    rsum = {1'b0, prod} + RND;
    q    = rsum[PROD_WIDTH:FRAC_BITS];
    lim  = prod_neg ? LIM_NEG : LIM_POS;
    qs   = (q > lim) ? lim[DATA_WIDTH-1:0] : q[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld.ld_term) begin
      term <= prod_neg ? signed'(~qs + DATA_WIDTH'(1)) : signed'(qs);
    end
  end

endmodule

>>> dv/pidc_drive_checker.sv
// ----------------------------------------------------------------------------
// pidc_drive_checker: drive value checker for the clamped PID controller
// Watches the register port and both streams, predicts each drive value from
// the accepted samples and compares it with what comes out.
// ----------------------------------------------------------------------------
module pidc_drive_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pidc_pkg::ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [pidc_pkg::CFG_WIDTH-1:0]   cfg_wdata,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [pidc_pkg::TDATA_WIDTH-1:0] s_tdata,   // [DATA_WIDTH-1:0] measured
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [pidc_pkg::TDATA_WIDTH-1:0] m_tdata,   // [DATA_WIDTH-1:0] drive
  output int                               pending,
  output int                               mismatches
);
  import pidc_pkg::*;

  // Shadow registers and controller state
  logic [GAIN_WIDTH-1:0]        p_gain = '0;
  logic [GAIN_WIDTH-1:0]        i_gain = '0;
  logic [GAIN_WIDTH-1:0]        d_gain = '0;
  logic signed [DATA_WIDTH-1:0] setpoint = '0;
  logic signed [DATA_WIDTH-1:0] floor_lim = '0;
  logic signed [DATA_WIDTH-1:0] ceil_lim = DATA_MAX;
  logic signed [DATA_WIDTH-1:0] integ = '0;
  logic signed [DATA_WIDTH-1:0] prev_meas = '0;
  logic                         first_sample = 1'b1;

  logic signed [DATA_WIDTH-1:0] expected_drive [$];
  int                           errors = 0;

  // Gain times signed value, scaled back by FRAC_BITS, rounded half away
  // from zero on the magnitude, saturated to the signed data range
  function automatic logic signed [DATA_WIDTH-1:0] scaled_product(
    input logic signed [ERR_WIDTH-1:0] a,
    input logic [GAIN_WIDTH-1:0]       g
  );
    logic                  neg;
    logic [ERR_WIDTH-1:0]  mag;
    logic [PROD_WIDTH:0]   full;
    logic [PROD_WIDTH:0]   lim;
    neg  = a[ERR_WIDTH-1];
    mag  = neg ? -a : a;
    full = mag * g;
    full = full + (1 << (FRAC_BITS - 1));
    full = full >> FRAC_BITS;
    lim  = {{(PROD_WIDTH + 1 - DATA_WIDTH){1'b0}}, DATA_MAX} + neg;
    if (full > lim) begin
      full = lim;
    end
    return neg ? (~full[DATA_WIDTH-1:0] + 1'b1) : full[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] fit_limits(
    input logic signed [DATA_WIDTH+1:0] v,
    input logic signed [DATA_WIDTH-1:0] lo,
    input logic signed [DATA_WIDTH-1:0] hi
  );
    if (v > hi) begin
      return hi;
    end
    if (v < lo) begin
      return lo;
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  // Advance the controller by one sample and return its drive value
  task automatic predict_drive(
    input  logic signed [DATA_WIDTH-1:0] meas,
    output logic signed [DATA_WIDTH-1:0] drive
  );
    logic signed [ERR_WIDTH-1:0]    err;
    logic signed [ERR_WIDTH-1:0]    slope;
    logic signed [DATA_WIDTH+1:0]   total;
    err   = setpoint - meas;
    slope = prev_meas - meas;
    total = integ + scaled_product(err, i_gain);
    integ = fit_limits(total, floor_lim, ceil_lim);
    total = scaled_product(err, p_gain) + integ;
    // derivative on measurement, skipped until a previous sample exists
    if (!first_sample) begin
      total = total + scaled_product(slope, d_gain);
    end
    first_sample = 1'b0;
    prev_meas    = meas;
    drive        = fit_limits(total, floor_lim, ceil_lim);
  endtask

  always @(posedge clk) begin : watch
    logic signed [DATA_WIDTH-1:0] want;
    logic signed [DATA_WIDTH-1:0] cand;
    if (rst) begin
      p_gain       = '0;
      i_gain       = '0;
      d_gain       = '0;
      setpoint     = '0;
      floor_lim    = '0;
      ceil_lim     = DATA_MAX;
      integ        = '0;
      prev_meas    = '0;
      first_sample = 1'b1;
      expected_drive.delete();
    end else begin
      // Track register writes; limit writes that would cross are dropped
      if (cfg_we) begin
        case (cfg_addr)
          REG_PROP_GAIN: begin
            p_gain = cfg_wdata[GAIN_WIDTH-1:0];
            integ  = '0;
          end
          REG_INTEG_GAIN: begin
            i_gain = cfg_wdata[GAIN_WIDTH-1:0];
            integ  = '0;
          end
          REG_DERIV_GAIN: begin
            d_gain = cfg_wdata[GAIN_WIDTH-1:0];
            integ  = '0;
          end
          REG_TARGET_VALUE: begin
            setpoint = cfg_wdata[DATA_WIDTH-1:0];
            integ    = '0;
          end
          REG_DRIVE_FLOOR: begin
            cand = cfg_wdata[DATA_WIDTH-1:0];
            if (cand < ceil_lim) begin
              floor_lim = cand;
            end
          end
          REG_DRIVE_CEILING: begin
            cand = cfg_wdata[DATA_WIDTH-1:0];
            if (floor_lim < cand) begin
              ceil_lim = cand;
            end
          end
          default: ;
        endcase
      end
      // Compare a drive transaction with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_drive.size() == 0) begin
          $display("%0t: drive %h arrived with no sample outstanding",
                   $time, m_tdata[DATA_WIDTH-1:0]);
          errors++;
        end else begin
          want = expected_drive.pop_front();
          if (m_tdata[DATA_WIDTH-1:0] !== want) begin
            $display("%0t: drive mismatch: expected %h, got %h",
                     $time, want, m_tdata[DATA_WIDTH-1:0]);
            errors++;
          end
        end
      end
      // Predict the drive for an accepted sample transaction
      if (s_tvalid && s_tready) begin
        predict_drive(s_tdata[DATA_WIDTH-1:0], want);
        expected_drive.push_back(want);
      end
    end
    pending    <= expected_drive.size();
    mismatches <= errors;
  end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the clamped PID controller
// Programs gains, setpoint and limits between phases, streams directed and
// random samples with bursty input and a stalling output, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
  import pidc_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 100;

  // Indexes with no register behind them
  localparam logic [ADDR_WIDTH-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ADDR_WIDTH-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = ~DATA_MAX;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [ADDR_WIDTH-1:0]  cfg_addr = '0;
  logic [CFG_WIDTH-1:0]   cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_WIDTH-1:0] s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_WIDTH-1:0] m_tdata;

  int       pending;
  int       mismatches;
  int       stall_tokens = 0;
  int       stall_served = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       burst_left = 1;
  int       idle_cycles = 0;

  logic signed [DATA_WIDTH-1:0] meas_walk = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pid_controller_clamped i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  pidc_drive_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // Receiver: long hold-off on request, otherwise a changing ready pattern
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (stall_served != stall_tokens) begin
      stall_served <= stall_tokens;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 128);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= (rx_tick % 4 == 0);
        default:   m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [ADDR_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer one sample, hold it until taken, then maybe open a gap
  task automatic push_sample(input logic [DATA_WIDTH-1:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 12);
    end
  endtask

  // Stop offering and wait until every drive value is back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [GAIN_WIDTH-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  // Mostly a random walk around the setpoint, some noise and extremes
  function automatic logic [DATA_WIDTH-1:0] next_measure();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? DATA_MIN : DATA_MAX;
      default: begin
        meas_walk = meas_walk + $signed(32'($urandom_range(0, 32'h0004_0000)))
                    - 32'sh0002_0000;
        return meas_walk;
      end
    endcase
  endfunction

  task automatic random_setting();
    logic signed [DATA_WIDTH-1:0] lo;
    logic signed [DATA_WIDTH-1:0] hi;
    logic signed [DATA_WIDTH-1:0] tgt;
    logic signed [DATA_WIDTH-1:0] t;
    if ($urandom_range(0, 3) == 0) begin
      tgt = $urandom;
    end else begin
      tgt = $signed(32'($urandom_range(0, 32'h00C8_0000))) - 32'sh0064_0000;
    end
    case ($urandom_range(0, 2))
      0: begin
        lo = DATA_MIN;
        hi = DATA_MAX;
      end
      1: begin
        lo = $urandom;
        hi = $urandom;
        if (lo > hi) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
      end
      default: begin
        lo = tgt - $signed(32'($urandom_range(1, 32'h0010_0000)));
        hi = tgt + $signed(32'($urandom_range(1, 32'h0010_0000)));
      end
    endcase
    write_reg(REG_PROP_GAIN, pick_gain());
    write_reg(REG_INTEG_GAIN, pick_gain());
    write_reg(REG_DERIV_GAIN, pick_gain());
    write_reg(REG_TARGET_VALUE, tgt);
    // order matters: a limit write that would cross the other one is dropped
    if ($urandom_range(0, 1)) begin
      write_reg(REG_DRIVE_FLOOR, lo);
      write_reg(REG_DRIVE_CEILING, hi);
    end else begin
      write_reg(REG_DRIVE_CEILING, hi);
      write_reg(REG_DRIVE_FLOOR, lo);
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_DRIVE_FLOOR, hi);
    end
    meas_walk = tgt;
  endtask

  initial begin : stimulus
    logic [DATA_WIDTH-1:0] mild_set [8];
    logic [DATA_WIDTH-1:0] extreme_set [8];
    mild_set = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                 32'hFFFF_FFFF, 32'h0005_0000, 32'h0005_0001, 32'h0004_8000};
    extreme_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Moderate gains; the first sample runs without a derivative term
    write_reg(REG_PROP_GAIN, 32'h0001_0000);
    write_reg(REG_INTEG_GAIN, 32'h0000_8000);
    write_reg(REG_DERIV_GAIN, 32'h0002_0000);
    write_reg(REG_TARGET_VALUE, 32'h0005_0000);
    write_reg(REG_DRIVE_FLOOR, -32'sh0064_0000);
    write_reg(REG_DRIVE_CEILING, 32'sh0064_0000);
    foreach (mild_set[i]) begin
      push_sample(mild_set[i]);
    end
    drain();

    // Full-scale gains and limits: products saturate both ways
    write_reg(REG_PROP_GAIN, '1);
    write_reg(REG_INTEG_GAIN, '1);
    write_reg(REG_DERIV_GAIN, '1);
    write_reg(REG_TARGET_VALUE, DATA_MAX);
    write_reg(REG_DRIVE_FLOOR, DATA_MIN);
    write_reg(REG_DRIVE_CEILING, DATA_MAX);
    // crossing limit writes and unmapped indexes must change nothing
    write_reg(REG_DRIVE_FLOOR, DATA_MAX);
    write_reg(REG_DRIVE_CEILING, DATA_MIN);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 32'h0000_1234);
    foreach (extreme_set[i]) begin
      push_sample(extreme_set[i]);
    end
    drain();

    write_reg(REG_TARGET_VALUE, DATA_MIN);
    push_sample(DATA_MAX);
    push_sample(DATA_MIN);
    push_sample('0);
    drain();

    // Random settings, each followed by a stream of samples
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_setting();
      if (phase == 2 || phase == 5) begin
        stall_tokens <= stall_tokens + 1;
      end
      repeat (PHASE_ITEMS) begin
        push_sample(next_measure());
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> pid_controller_clamped.f
rtl/core/pidc_pkg.sv
rtl/core/pidc_gain_mul.sv
rtl/core/pid_controller_clamped.sv
dv/pidc_drive_checker.sv
dv/tb_top.sv
